// File: sv/sbsrp_pkg.sv
// Shared types, constants and helpers for the styl box record parser.
package sbsrp_pkg;

	localparam int MAX_SAMPLE_BYTES = 262143;
	localparam int POS_W = 18;
	localparam int REC_BYTES = 12;
	localparam int HDR_BYTES = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] MAX_RECORDS_RESET = 16'd64;
	localparam logic [31:0] STYL_TYPE = 32'h7374796c;

	localparam logic KIND_STYLE = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TEXT,
		PH_HDR,
		PH_CNT_HI,
		PH_CNT_LO,
		PH_RECORD,
		PH_SKIP,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic kind;
		logic [8*REC_BYTES-1:0] rec;
		logic [15:0] text_bytes;
		logic decoded_ok;
		logic clears;
		logic malformed;
		logic last_result;
	} sbsrp_entry_t;

	typedef struct packed {
		logic v0;
		logic v1;
		sbsrp_entry_t e0;
		sbsrp_entry_t e1;
	} sbsrp_push_t;

	function automatic logic [7:0] styl_char(input logic [1:0] sel);
		logic [7:0] c;
		unique case (sel)
			2'd0: c = STYL_TYPE[31:24];
			2'd1: c = STYL_TYPE[23:16];
			2'd2: c = STYL_TYPE[15:8];
			default: c = STYL_TYPE[7:0];
		endcase
		return c;
	endfunction

endpackage

// File: sv/sbsrp_front.sv
// Front end: byte parser that classifies bytes and builds record and summary transactions.
module sbsrp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [7:0]                 data_byte,
	input  logic [17:0]                sample_length,
	input  logic                       last_byte,
	input  logic [15:0]                max_style_records,
	output sbsrp_pkg::sbsrp_push_t     push
);
	import sbsrp_pkg::*;

	phase_t phase_q, n_phase;
	logic [POS_W-1:0] pos_q, n_pos;
	logic [15:0] text_q, n_text;
	logic [31:0] size_q, n_size;
	logic [31:0] left_q, n_left;
	logic style_q, n_style;
	logic [15:0] rl_q, n_rl;
	logic [3:0] idx_q, n_idx;
	logic mal_q, n_mal;
	logic clr_q, n_clr;
	logic [7:0] rec_q [REC_BYTES];

	logic in_range;
	logic [POS_W:0] next_pos;
	logic start_ok;
	logic [19:0] avail;
	logic [31:0] ln;
	logic [31:0] body;
	logic [15:0] rl;
	logic [15:0] tl;
	logic rec_done;
	sbsrp_entry_t rec_ent, sum_ent;

	assign next_pos = {1'b0, pos_q} + 1'b1;
	assign in_range = ({1'b0, pos_q} < {1'b0, sample_length}) &&
		(pos_q != POS_W'(MAX_SAMPLE_BYTES));
	assign start_ok = (next_pos + (POS_W+1)'(HDR_BYTES)) <= {1'b0, sample_length};
	assign avail = {2'b0, sample_length} - {2'b0, pos_q} + 20'd7;
	assign ln = left_q - 32'd1;
	assign body = size_q - 32'(HDR_BYTES);

	function automatic phase_t finish_phase(input logic [31:0] rem, input logic ok);
		phase_t p;
		if (rem != 32'd0)
			p = PH_SKIP;
		else if (ok)
			p = PH_HDR;
		else
			p = PH_IDLE;
		return p;
	endfunction

	always_comb begin
		n_phase = phase_q;
		n_pos = pos_q;
		n_text = text_q;
		n_size = size_q;
		n_left = left_q;
		n_style = style_q;
		n_rl = rl_q;
		n_idx = idx_q;
		n_mal = mal_q;
		n_clr = clr_q;
		rec_done = 1'b0;
		rl = rl_q;
		tl = {text_q[15:8], data_byte};
		if (in_range) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					n_text = {data_byte, 8'h00};
					n_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					n_text = tl;
					if (tl == 16'd0) begin
						n_clr = 1'b1;
						n_phase = PH_IDLE;
					end else if (({3'b0, tl} + 19'd2) > {1'b0, sample_length}) begin
						n_mal = 1'b1;
						n_phase = PH_IDLE;
					end else begin
						n_left = {16'h0000, tl};
						n_phase = PH_TEXT;
					end
				end
				PH_TEXT, PH_SKIP: begin
					n_left = ln;
					if (ln == 32'd0) begin
						n_phase = start_ok ? PH_HDR : PH_IDLE;
						n_idx = '0;
						n_size = '0;
						n_style = 1'b1;
					end
				end
				PH_HDR: begin
					if (idx_q < 4'd4)
						n_size = {size_q[23:0], data_byte};
					else if (data_byte != styl_char(idx_q[1:0]))
						n_style = 1'b0;
					n_idx = idx_q + 4'd1;
					if (idx_q == 4'(HDR_BYTES - 1)) begin
						if (size_q < 32'(HDR_BYTES) || size_q > {12'h000, avail}) begin
							n_mal = 1'b1;
							n_phase = PH_IDLE;
						end else begin
							n_left = body;
							if (n_style && body < 32'd2) begin
								n_mal = 1'b1;
								n_phase = finish_phase(body, start_ok);
								n_idx = '0;
								n_size = '0;
								n_style = 1'b1;
							end else if (n_style) begin
								n_phase = PH_CNT_HI;
							end else begin
								n_phase = finish_phase(body, start_ok);
								n_idx = '0;
								n_size = '0;
								n_style = 1'b1;
							end
						end
					end
				end
				PH_CNT_HI, PH_CNT_LO, PH_RECORD: begin
					n_left = ln;
					if (phase_q == PH_CNT_HI) begin
						n_rl = {data_byte, 8'h00};
						n_phase = PH_CNT_LO;
					end else begin
						if (phase_q == PH_CNT_LO) begin
							rl = {rl_q[15:8], data_byte};
							if (rl > max_style_records) begin
								rl = max_style_records;
								n_mal = 1'b1;
							end
						end else begin
							n_idx = idx_q + 4'd1;
							if (idx_q == 4'(REC_BYTES - 1)) begin
								rec_done = 1'b1;
								rl = rl_q - 16'd1;
							end
						end
						n_rl = rl;
						if (phase_q == PH_CNT_LO || rec_done) begin
							n_idx = '0;
							if (rl == 16'd0) begin
								n_phase = finish_phase(ln, start_ok);
								n_size = '0;
								n_style = 1'b1;
							end else if (ln < 32'(REC_BYTES)) begin
								n_mal = 1'b1;
								n_phase = finish_phase(ln, start_ok);
								n_size = '0;
								n_style = 1'b1;
							end else begin
								n_phase = PH_RECORD;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end else begin
			n_mal = 1'b1;
		end
		if (pos_q != POS_W'(MAX_SAMPLE_BYTES))
			n_pos = next_pos[POS_W-1:0];
		if (last_byte && next_pos != {1'b0, sample_length})
			n_mal = 1'b1;

		rec_ent = '0;
		rec_ent.kind = KIND_STYLE;
		rec_ent.rec = {rec_q[0], rec_q[1], rec_q[2], rec_q[3], rec_q[4], rec_q[5],
			rec_q[6], rec_q[7], rec_q[8], rec_q[9], rec_q[10], data_byte};
		rec_ent.last_result = !last_byte;

		sum_ent = '0;
		sum_ent.kind = KIND_SUMMARY;
		sum_ent.text_bytes = n_text;
		sum_ent.decoded_ok = (n_phase != PH_LEN_HI) && (n_phase != PH_LEN_LO);
		sum_ent.clears = n_clr;
		sum_ent.malformed = n_mal;
		sum_ent.last_result = 1'b1;

		push = '0;
		if (accept) begin
			if (rec_done) begin
				push.v0 = 1'b1;
				push.e0 = rec_ent;
				push.v1 = last_byte;
				push.e1 = sum_ent;
			end else begin
				push.v0 = last_byte;
				push.e0 = sum_ent;
			end
		end

		if (last_byte) begin
			n_phase = PH_LEN_HI;
			n_pos = '0;
			n_text = '0;
			n_size = '0;
			n_left = '0;
			n_style = 1'b0;
			n_rl = '0;
			n_idx = '0;
			n_mal = 1'b0;
			n_clr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_HI;
			pos_q <= '0;
			text_q <= '0;
			size_q <= '0;
			left_q <= '0;
			style_q <= 1'b0;
			rl_q <= '0;
			idx_q <= '0;
			mal_q <= 1'b0;
			clr_q <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase;
			pos_q <= n_pos;
			text_q <= n_text;
			size_q <= n_size;
			left_q <= n_left;
			style_q <= n_style;
			rl_q <= n_rl;
			idx_q <= n_idx;
			mal_q <= n_mal;
			clr_q <= n_clr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_range && phase_q == PH_RECORD && idx_q < 4'(REC_BYTES))
			rec_q[idx_q] <= data_byte;
	end

endmodule

// File: sv/sbsrp_queue.sv
// Short result queue between the parser and the output stage, up to two writes per cycle.
module sbsrp_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sbsrp_pkg::sbsrp_push_t     push,
	input  logic                       pop,
	output logic                       room,
	output logic                       head_valid,
	output sbsrp_pkg::sbsrp_entry_t    head
);
	import sbsrp_pkg::*;

	sbsrp_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] n_push;

	assign n_push = QCNT_W'(push.v0) + QCNT_W'(push.v1);
	assign room = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wptr_q] <= push.e0;
		if (push.v1)
			mem_q[wptr_q + QPTR_W'(1)] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + n_push[QPTR_W-1:0];
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

endmodule

// File: sv/sbsrp_back.sv
// Back end: output register that presents one result transaction at a time.
module sbsrp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  sbsrp_pkg::sbsrp_entry_t    head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       result_kind,
	output logic [15:0]                start_char,
	output logic [15:0]                end_char,
	output logic [15:0]                font_id,
	output logic [7:0]                 face_flags,
	output logic [7:0]                 font_size,
	output logic [31:0]                text_color,
	output logic [15:0]                text_bytes,
	output logic                       decoded_ok,
	output logic                       clears_screen,
	output logic                       malformed,
	output logic                       last_result
);
	import sbsrp_pkg::*;

	logic valid_q;
	sbsrp_entry_t ent_q;

	assign pop = head_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= head;
	end

	assign out_valid = valid_q;
	assign result_kind = ent_q.kind;
	assign start_char = ent_q.rec[95:80];
	assign end_char = ent_q.rec[79:64];
	assign font_id = ent_q.rec[63:48];
	assign face_flags = ent_q.rec[47:40];
	assign font_size = ent_q.rec[39:32];
	assign text_color = ent_q.rec[31:0];
	assign text_bytes = ent_q.text_bytes;
	assign decoded_ok = ent_q.decoded_ok;
	assign clears_screen = ent_q.clears;
	assign malformed = ent_q.malformed;
	assign last_result = ent_q.last_result;

endmodule

// File: sv/styl_box_style_record_parser_core.sv
// Top level of the styl box record parser: config register, parser, result queue, output stage.
// The block takes one sample byte per cycle while in_stall is low. The parser updates its
// state on the byte itself and writes zero, one or two result transactions (a style
// record when its twelfth byte arrives, a summary on the last byte) into a four-entry
// queue; a byte is taken whenever the queue has two free entries, so a stalled output
// holds input off only once fewer than two entries are free. Results pass from a queue
// entry through an output register, one per cycle while out_stall is low; a byte that
// completes a record and ends the sample yields the record first and then the summary.
// max_style_records is written through the cfg channel, which is always ready.
module styl_box_style_record_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [17:0] sample_length,
	input  logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [15:0] start_char,
	output logic [15:0] end_char,
	output logic [15:0] font_id,
	output logic [7:0]  face_flags,
	output logic [7:0]  font_size,
	output logic [31:0] text_color,
	output logic [15:0] text_bytes,
	output logic        decoded_ok,
	output logic        clears_screen,
	output logic        malformed,
	output logic        last_result
);
	import sbsrp_pkg::*;

	logic [15:0] max_q;
	logic accept;
	logic room;
	logic head_valid;
	logic pop;
	sbsrp_push_t push;
	sbsrp_entry_t head;

	assign cfg_ready = 1'b1;
	assign in_stall = !room;
	assign accept = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RECORDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	sbsrp_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.data_byte         (data_byte),
		.sample_length     (sample_length),
		.last_byte         (last_byte),
		.max_style_records (max_q),
		.push              (push)
	);

	sbsrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (head_valid),
		.head       (head)
	);

	sbsrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.start_char    (start_char),
		.end_char      (end_char),
		.font_id       (font_id),
		.face_flags    (face_flags),
		.font_size     (font_size),
		.text_color    (text_color),
		.text_bytes    (text_bytes),
		.decoded_ok    (decoded_ok),
		.clears_screen (clears_screen),
		.malformed     (malformed),
		.last_result   (last_result)
	);

endmodule

// File: bench/tb_styl_box_style_record_parser_core.sv
// Self-checking bench for the styl box style record parser: byte stream in, records and summaries out.
module tb_styl_box_style_record_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsrp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0]  b;
		logic [17:0] len;
		logic        last;
	} sample_byte_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] start_c;
		logic [15:0] end_c;
		logic [15:0] font;
		logic [7:0]  face;
		logic [7:0]  fsize;
		logic [31:0] color;
		logic [15:0] tbytes;
		logic        ok;
		logic        clr;
		logic        bad;
		logic        lastr;
	} style_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic [17:0] sample_length = '0;
	logic        last_byte = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [15:0] start_char;
	logic [15:0] end_char;
	logic [15:0] font_id;
	logic [7:0]  face_flags;
	logic [7:0]  font_size;
	logic [31:0] text_color;
	logic [15:0] text_bytes;
	logic        decoded_ok;
	logic        clears_screen;
	logic        malformed;
	logic        last_result;

	sample_byte_t  byte_feed[$];
	style_result_t results_due[$];
	logic [7:0]    smp[$];
	int            fed = 0;
	int            errors = 0;
	int            cycles = 0;
	logic          steady = 1'b0;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	int            hold_left = 0;

	phase_t      ph;
	logic [17:0] pos_cnt;
	logic [15:0] txt_len;
	logic [31:0] bsize;
	logic [31:0] bleft;
	logic        is_styl;
	logic [15:0] recs_left;
	logic [3:0]  rec_idx;
	logic [7:0]  rec_buf[REC_BYTES];
	logic        bad_seen;
	logic        clr_seen;
	logic [15:0] max_recs;

	styl_box_style_record_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.sample_length(sample_length),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.start_char(start_char),
		.end_char(end_char),
		.font_id(font_id),
		.face_flags(face_flags),
		.font_size(font_size),
		.text_color(text_color),
		.text_bytes(text_bytes),
		.decoded_ok(decoded_ok),
		.clears_screen(clears_screen),
		.malformed(malformed),
		.last_result(last_result)
	);

	always #5 clk = ~clk;

	function automatic void clear_parse();
		ph = PH_LEN_HI;
		pos_cnt = '0;
		txt_len = '0;
		bsize = '0;
		bleft = '0;
		is_styl = 1'b0;
		recs_left = '0;
		rec_idx = '0;
		foreach (rec_buf[i]) rec_buf[i] = '0;
		bad_seen = 1'b0;
		clr_seen = 1'b0;
	endfunction

	function automatic void start_box(input int nxt, input int len);
		if (longint'(nxt) + HDR_BYTES <= longint'(len)) begin
			ph = PH_HDR;
			rec_idx = '0;
			bsize = '0;
			is_styl = 1'b1;
		end else begin
			ph = PH_IDLE;
		end
	endfunction

	function automatic void finish_body(input int nxt, input int len);
		if (bleft > 0) ph = PH_SKIP;
		else start_box(nxt, len);
	endfunction

	function automatic void next_record(input int nxt, input int len);
		if (recs_left == 0) begin
			finish_body(nxt, len);
		end else if (bleft < REC_BYTES) begin
			bad_seen = 1'b1;
			finish_body(nxt, len);
		end else begin
			ph = PH_RECORD;
			rec_idx = '0;
		end
	endfunction

	function automatic bit parse_one(input logic [7:0] b, input int pos, input int len);
		int     nxt;
		longint avail;
		bit     done;
		nxt = pos + 1;
		done = 1'b0;
		case (ph)
			PH_LEN_HI: begin
				txt_len = {b, 8'h00};
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				txt_len[7:0] = b;
				if (txt_len == 0) begin
					clr_seen = 1'b1;
					ph = PH_IDLE;
				end else if (2 + int'(txt_len) > len) begin
					bad_seen = 1'b1;
					ph = PH_IDLE;
				end else begin
					bleft = 32'(txt_len);
					ph = PH_TEXT;
				end
			end
			PH_TEXT, PH_SKIP: begin
				bleft = bleft - 32'd1;
				if (bleft == 0) start_box(nxt, len);
			end
			PH_HDR: begin
				if (rec_idx < 4) bsize = {bsize[23:0], b};
				else if (b != STYL_TYPE[8*(7-rec_idx) +: 8]) is_styl = 1'b0;
				rec_idx = rec_idx + 4'd1;
				if (rec_idx == HDR_BYTES) begin
					avail = longint'(len) - pos + 7;
					if (bsize < HDR_BYTES || longint'(bsize) > avail) begin
						bad_seen = 1'b1;
						ph = PH_IDLE;
					end else begin
						bleft = bsize - 32'(HDR_BYTES);
						if (is_styl && bleft < 2) begin
							bad_seen = 1'b1;
							finish_body(nxt, len);
						end else if (is_styl) begin
							ph = PH_CNT_HI;
						end else begin
							finish_body(nxt, len);
						end
					end
				end
			end
			PH_CNT_HI: begin
				recs_left = {b, 8'h00};
				bleft = bleft - 32'd1;
				ph = PH_CNT_LO;
			end
			PH_CNT_LO: begin
				recs_left[7:0] = b;
				bleft = bleft - 32'd1;
				if (recs_left > max_recs) begin
					recs_left = max_recs;
					bad_seen = 1'b1;
				end
				next_record(nxt, len);
			end
			PH_RECORD: begin
				rec_buf[rec_idx] = b;
				rec_idx = rec_idx + 4'd1;
				bleft = bleft - 32'd1;
				if (rec_idx >= REC_BYTES) begin
					recs_left = recs_left - 16'd1;
					next_record(nxt, len);
					done = 1'b1;
				end
			end
			default: ;
		endcase
		return done;
	endfunction

	function automatic void parse_sample_byte(input logic [7:0] b, input logic [17:0] len,
			input logic last);
		int            pos;
		bit            rec_done;
		style_result_t r;
		pos = int'(pos_cnt);
		rec_done = 1'b0;
		if (pos < int'(len) && pos < MAX_SAMPLE_BYTES) rec_done = parse_one(b, pos, int'(len));
		else bad_seen = 1'b1;
		if (pos_cnt < MAX_SAMPLE_BYTES) pos_cnt = pos_cnt + 18'd1;
		if (rec_done) begin
			r = '0;
			r.kind = KIND_STYLE;
			r.start_c = {rec_buf[0], rec_buf[1]};
			r.end_c = {rec_buf[2], rec_buf[3]};
			r.font = {rec_buf[4], rec_buf[5]};
			r.face = rec_buf[6];
			r.fsize = rec_buf[7];
			r.color = {rec_buf[8], rec_buf[9], rec_buf[10], rec_buf[11]};
			r.lastr = !last;
			results_due.insert(results_due.size(), r);
		end
		if (last) begin
			if (pos + 1 != int'(len)) bad_seen = 1'b1;
			r = '0;
			r.kind = KIND_SUMMARY;
			r.tbytes = txt_len;
			r.ok = (ph != PH_LEN_HI && ph != PH_LEN_LO);
			r.clr = clr_seen;
			r.bad = bad_seen;
			r.lastr = 1'b1;
			results_due.insert(results_due.size(), r);
			clear_parse();
		end
	endfunction

	function automatic void cmp_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
		end
	endfunction

	function automatic void take_result();
		style_result_t w;
		if (results_due.size() == 0) begin
			errors++;
			$display("%0t ns: unexpected result, expected none, actual kind %0d", $time,
				result_kind);
			return;
		end
		w = results_due.pop_front();
		cmp_field("result_kind", 32'(w.kind), 32'(result_kind));
		cmp_field("start_char", 32'(w.start_c), 32'(start_char));
		cmp_field("end_char", 32'(w.end_c), 32'(end_char));
		cmp_field("font_id", 32'(w.font), 32'(font_id));
		cmp_field("face_flags", 32'(w.face), 32'(face_flags));
		cmp_field("font_size", 32'(w.fsize), 32'(font_size));
		cmp_field("text_color", w.color, text_color);
		cmp_field("text_bytes", 32'(w.tbytes), 32'(text_bytes));
		cmp_field("decoded_ok", 32'(w.ok), 32'(decoded_ok));
		cmp_field("clears_screen", 32'(w.clr), 32'(clears_screen));
		cmp_field("malformed", 32'(w.bad), 32'(malformed));
		cmp_field("last_result", 32'(w.lastr), 32'(last_result));
	endfunction

	function automatic void send_sample(input int len);
		sample_byte_t nb;
		foreach (smp[i]) begin
			nb.b = smp[i];
			nb.len = 18'(len);
			nb.last = (i == smp.size() - 1);
			byte_feed.insert(byte_feed.size(), nb);
			fed++;
		end
	endfunction

	function automatic void add_byte(input logic [7:0] v);
		smp.insert(smp.size(), v);
	endfunction

	function automatic void random_sample();
		int          sel, nbox, nrec, body, k, j, r, len;
		logic [15:0] tlen, cnt;
		logic [31:0] size_w, type_w;
		smp = {};
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
			send_sample($urandom_range(0, MAX_SAMPLE_BYTES));
			return;
		end
		if (sel < 13) tlen = '0;
		else if (sel < 18) tlen = 16'($urandom_range(7, 65535));
		else tlen = 16'($urandom_range(1, 6));
		add_byte(tlen[15:8]);
		add_byte(tlen[7:0]);
		if (tlen > 6) begin
			repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
		end else if (tlen != 0) begin
			repeat (tlen) add_byte(8'($urandom));
			nbox = $urandom_range(0, 3);
			repeat (nbox) begin
				r = $urandom_range(0, 99);
				type_w = STYL_TYPE;
				k = -1;
				nrec = 0;
				cnt = '0;
				if (r < 60) begin
					nrec = $urandom_range(0, 3);
					if ($urandom_range(0, 9) == 0) nrec = $urandom_range(4, 6);
					cnt = 16'(nrec);
					k = $urandom_range(0, 19);
					if (k == 0) cnt = 16'(nrec + $urandom_range(1, 3));
					else if (k == 1) cnt = 16'($urandom);
					body = 2 + REC_BYTES * nrec;
					if (k == 2) body += $urandom_range(1, 11);
					if (k == 3) begin
						j = $urandom_range(0, 3);
						type_w[8*j +: 8] = type_w[8*j +: 8] ^ 8'h01;
					end
					if (k == 4) body = $urandom_range(0, 1);
				end else if (r < 85) begin
					type_w = $urandom;
					body = $urandom_range(0, 5);
				end else begin
					if ($urandom_range(0, 1) == 0) type_w = $urandom;
					body = $urandom_range(0, 6);
				end
				size_w = body + HDR_BYTES;
				if (r >= 85 && r < 92) size_w = $urandom_range(0, 7);
				else if (r >= 92 && $urandom_range(0, 1) == 0) size_w = $urandom;
				else if (r >= 92) size_w = body + HDR_BYTES + $urandom_range(1, 40);
				for (j = 3; j >= 0; j--) add_byte(size_w[8*j +: 8]);
				for (j = 3; j >= 0; j--) add_byte(type_w[8*j +: 8]);
				if (r < 60 && k != 4) begin
					add_byte(cnt[15:8]);
					add_byte(cnt[7:0]);
					repeat (body - 2) add_byte(8'($urandom));
				end else begin
					repeat (body) add_byte(8'($urandom));
				end
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 7)) add_byte(8'($urandom));
		end
		len = smp.size();
		k = $urandom_range(0, 19);
		if (k == 0) len += $urandom_range(1, 3);
		else if (k == 1) len -= $urandom_range(1, 2);
		else if (k == 2) len = $urandom_range(0, MAX_SAMPLE_BYTES);
		send_sample(len);
	endfunction

	task automatic wait_idle();
		while (byte_feed.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_records(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_recs = v;
	endtask

	always @(posedge clk) begin : drive_bytes
		sample_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) parse_sample_byte(data_byte, sample_length, last_byte);
			if (!in_valid || !in_stall) begin
				if (byte_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
					nb = byte_feed.pop_front();
					in_valid <= 1'b1;
					data_byte <= nb.b;
					sample_length <= nb.len;
					last_byte <= nb.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) take_result();
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 25);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [15:0] caps[6];
		int          base;
		caps = '{16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd2, MAX_RECORDS_RESET};
		caps[3] = 16'($urandom_range(1, 8));
		clear_parse();
		max_recs = MAX_RECORDS_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		smp = {8'h00, 8'h00};
		send_sample(2);
		smp = {8'hFF};
		send_sample(1);
		smp = {8'h00, 8'h05, 8'h41};
		send_sample(3);
		smp = {8'h00, 8'h00, 8'h7E};
		send_sample(2);
		smp = {8'h00, 8'h00};
		send_sample(5);
		smp = {8'hFF, 8'hFF};
		send_sample(MAX_SAMPLE_BYTES);
		smp = {8'h00};
		send_sample(0);
		smp = {8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h00};
		send_sample(6);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_max_records(caps[p]);
			steady <= (p == 1);
			hold_req <= (p == 2);
			base = fed;
			while (fed - base < PHASE_BYTES) random_sample();
			wait_idle();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/sbsrp_pkg.sv
sv/sbsrp_front.sv
sv/sbsrp_queue.sv
sv/sbsrp_back.sv
sv/styl_box_style_record_parser_core.sv
bench/tb_styl_box_style_record_parser_core.sv
